/* hw/rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Bitmap geometry.
    localparam int BITMAP_BYTES = 512;
    localparam int TOTAL_PAGES  = BITMAP_BYTES * 8;
    localparam int WORD_BITS    = 32;
    localparam int WORD_SHIFT   = 5;
    localparam int NUM_WORDS    = (BITMAP_BYTES + 3) / 4;
    localparam int WORD_AW      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int COUNT_W      = $clog2(TOTAL_PAGES + 1);
    localparam int PAGE_W       = (COUNT_W > 12) ? COUNT_W : 12;
    localparam int FIELD_W      = 12;

    // Bits of the last word that lie beyond the last page count as used.
    localparam int LAST_VALID_BITS = TOTAL_PAGES - (NUM_WORDS - 1) * WORD_BITS;

    typedef logic [1:0]            t_func;
    typedef logic [FIELD_W-1:0]    t_page;
    typedef logic [PAGE_W-1:0]     t_pnum;
    typedef logic [WORD_AW-1:0]    t_waddr;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [WORD_SHIFT-1:0] t_bitpos;
    typedef logic [COUNT_W-1:0]    t_count;

    localparam t_word  ALL_ONES  = 32'hffffffff;
    localparam t_word  LAST_PAD  = (LAST_VALID_BITS >= WORD_BITS) ? t_word'(0) :
                                   ~((t_word'(1) << LAST_VALID_BITS) - t_word'(1));
    localparam t_waddr LAST_WORD = t_waddr'(NUM_WORDS - 1);
    localparam t_pnum  TOTAL_PNUM = t_pnum'(TOTAL_PAGES);
    localparam t_count TOTAL_CNT  = t_count'(TOTAL_PAGES);

    // Operation codes.
    localparam t_func FUNC_ALLOC = 2'd0;
    localparam t_func FUNC_FREE  = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    // Result of the find-first-zero unit.
    typedef struct packed {
        logic    found;
        t_bitpos pos;
    } t_ffz;

endpackage

/* hw/rtl/bpa_req_if.sv */
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: one item carries an operation and a page index.
// ----------------------------------------------------------------------------
interface bpa_req_if;
    import bpa_pkg::*;

    logic  valid;
    logic  ready;
    t_func func;
    t_page page_index;

    modport source (output valid, output func, output page_index, input ready);
    modport sink   (input valid, input func, input page_index, output ready);
endinterface

/* hw/rtl/bpa_rsp_if.sv */
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel: one item carries the status and the granted page.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
    import bpa_pkg::*;

    logic  valid;
    logic  ready;
    logic  ok;
    t_page granted_page;

    modport source (output valid, output ok, output granted_page, input ready);
    modport sink   (input valid, input ok, input granted_page, output ready);
endinterface

/* hw/rtl/bpa_ffz.sv */
// ----------------------------------------------------------------------------
// bpa_ffz
// Find-first-zero unit: locates the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bpa_ffz (
    input  bpa_pkg::t_word i_word,
    output bpa_pkg::t_ffz  o_res
);
    import bpa_pkg::*;

    // Priority encode from the top down so the lowest clear bit wins.
    always_comb begin
        o_res.found = (i_word != ALL_ONES);
        o_res.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_res.pos = t_bitpos'(i);
            end
        end
    end

endmodule

/* hw/rtl/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator over an in-use bitmap held as 32-bit words in a memory.
// A sequencer drives one find-first-zero unit word by word for the rescan.
// ----------------------------------------------------------------------------
// Sequence: a query, free or failed allocate goes through S_CHECK and S_DONE into the
// output register; a successful allocate also passes S_SCAN, where the rescan examines the
// words up to the first one with a free page (all NUM_WORDS when none is left), one word
// per cycle through the one read port.
// Throughput: one item at a time; the next item is accepted once the result
// sits in the output register. Reset clears the row valid bits: all pages free.
module bitmap_page_allocator (
    input  logic i_clk,
    input  logic i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);
    import bpa_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    t_func      r_func, n_func;
    t_page      r_page, n_page;
    t_count     r_count, n_count;
    t_pnum      r_next_free, n_next_free;
    logic       r_nf_valid, n_nf_valid;
    t_waddr     r_scan_addr, n_scan_addr;
    t_waddr     r_eval_addr, n_eval_addr;
    logic       r_eval_pend, n_eval_pend;
    logic       r_res_ok, n_res_ok;
    t_page      r_res_page, n_res_page;
    logic       r_out_valid, n_out_valid;
    logic       r_out_ok, n_out_ok;
    t_page      r_out_page, n_out_page;

    // Bitmap memory with one valid bit per row; an unwritten row reads as free.
    t_word  r_mem [NUM_WORDS];
    logic   r_vld [NUM_WORDS];
    t_word  r_rdata;
    logic   r_rd_vld;
    t_waddr rd_addr;
    logic   wr_en;
    t_waddr wr_addr;
    t_word  wr_data;
    t_word  rd_word;

    // Decoding of the incoming and latched page numbers.
    t_pnum  in_pnum;
    logic   in_range_new;
    t_waddr in_word;
    t_pnum  cur_pnum;
    logic   cur_in_range;
    t_waddr cur_word;
    t_waddr nf_word;
    t_bitpos sel_pos;
    t_word   sel_mask;
    logic    alloc_ok;

    // Scan evaluation through the find-first-zero unit.
    t_word scan_word;
    t_ffz  ffz_res;

    assign in_pnum      = t_pnum'(i_req.page_index);
    assign in_range_new = (in_pnum < TOTAL_PNUM);
    assign in_word      = in_range_new ? t_waddr'(in_pnum >> WORD_SHIFT) : '0;
    assign cur_pnum     = t_pnum'(r_page);
    assign cur_in_range = (cur_pnum < TOTAL_PNUM);
    assign cur_word     = cur_in_range ? t_waddr'(cur_pnum >> WORD_SHIFT) : '0;
    assign nf_word      = t_waddr'(r_next_free >> WORD_SHIFT);
    assign rd_word      = r_rd_vld ? r_rdata : '0;

    assign sel_pos  = (r_func == FUNC_ALLOC) ? r_next_free[WORD_SHIFT-1:0]
                                             : r_page[WORD_SHIFT-1:0];
    assign sel_mask = t_word'(1) << sel_pos;
    assign alloc_ok = (r_count < TOTAL_CNT) && r_nf_valid && (r_next_free < TOTAL_PNUM);

    assign scan_word = rd_word | ((r_eval_addr == LAST_WORD) ? LAST_PAD : t_word'(0));

    bpa_ffz u_ffz (
        .i_word (scan_word),
        .o_res  (ffz_res)
    );

    // Read address: next-free word (allocate) or item's word on accept, scan pointer else.
    always_comb begin
        rd_addr = r_scan_addr;
        if (r_state == S_IDLE) begin
            rd_addr = (i_req.func == FUNC_ALLOC) ? nf_word : in_word;
        end
    end

    // Memory read and write, read data registered.
    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Row valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out_ok;
    assign o_rsp.granted_page = r_out_page;

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_page      = r_page;
        n_count     = r_count;
        n_next_free = r_next_free;
        n_nf_valid  = r_nf_valid;
        n_scan_addr = r_scan_addr;
        n_eval_addr = r_eval_addr;
        n_eval_pend = r_eval_pend;
        n_res_ok    = r_res_ok;
        n_res_page  = r_res_page;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_page  = r_out_page;
        wr_en       = 1'b0;
        wr_addr     = cur_word;
        wr_data     = rd_word;

        // The output register empties when the consumer takes the item.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_page  = i_req.page_index;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_res_ok   = 1'b0;
                n_res_page = '0;
                n_state    = S_DONE;
                unique case (r_func)
                    FUNC_ALLOC: begin
                        if (alloc_ok) begin
                            wr_en       = 1'b1;
                            wr_addr     = nf_word;
                            wr_data     = rd_word | sel_mask;
                            n_count     = r_count + t_count'(1);
                            n_res_ok    = 1'b1;
                            n_res_page  = r_next_free[FIELD_W-1:0];
                            n_scan_addr = '0;
                            n_eval_pend = 1'b0;
                            n_state     = S_SCAN;
                        end
                    end
                    FUNC_FREE: begin
                        if (cur_in_range && ((rd_word & sel_mask) != '0)) begin
                            wr_en    = 1'b1;
                            wr_addr  = cur_word;
                            wr_data  = rd_word & ~sel_mask;
                            n_res_ok = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - t_count'(1);
                            end
                            if (!r_nf_valid) begin
                                n_next_free = cur_pnum;
                                n_nf_valid  = 1'b1;
                            end
                        end
                    end
                    FUNC_QUERY: begin
                        n_res_ok = cur_in_range && ((rd_word & sel_mask) == '0);
                    end
                    default: begin
                        n_res_ok = 1'b0;
                    end
                endcase
            end

            S_SCAN: begin
                // One word read per cycle; the word read last cycle is evaluated now.
                n_eval_pend = 1'b1;
                n_eval_addr = r_scan_addr;
                if (r_scan_addr != LAST_WORD) begin
                    n_scan_addr = r_scan_addr + t_waddr'(1);
                end
                if (r_eval_pend) begin
                    if (ffz_res.found) begin
                        n_next_free = (t_pnum'(r_eval_addr) << WORD_SHIFT) |
                                      t_pnum'(ffz_res.pos);
                        n_nf_valid  = 1'b1;
                        n_eval_pend = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_eval_addr == LAST_WORD) begin
                        n_next_free = '0;
                        n_nf_valid  = 1'b0;
                        n_eval_pend = 1'b0;
                        n_state     = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_page  = r_res_page;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_free <= '0;
            r_nf_valid  <= 1'b1;
            r_eval_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_free <= n_next_free;
            r_nf_valid  <= n_nf_valid;
            r_eval_pend <= n_eval_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_page      <= n_page;
        r_scan_addr <= n_scan_addr;
        r_eval_addr <= n_eval_addr;
        r_res_ok    <= n_res_ok;
        r_res_page  <= n_res_page;
        r_out_ok    <= n_out_ok;
        r_out_page  <= n_out_page;
    end

endmodule
